[design/assert_macros.svh]
// Assertion macros used by the indexed sequence list datapath.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ISL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ISL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[design/isl_pkg.sv]
// Package for the indexed sequence list: opcodes, status codes, FSM states
// and the command/status structs between controller and datapath. No dependencies.
package isl_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int DATA_W        = 32;
  localparam int INDEX_W       = 16;
  localparam int COUNT_OUT_W   = 7;

  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_ADD_HEAD = 3'd1,
    OP_ADD_TAIL = 3'd2,
    OP_ADD_AT   = 3'd3,
    OP_DELETE   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What a request turns into once decoded against the current count.
  typedef enum logic [1:0] {
    K_REJECT = 2'd0,
    K_READ   = 2'd1,
    K_INSERT = 2'd2,
    K_DELETE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SHIFT,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;          // capture the input beat
    logic decide;        // latch the decoded request
    logic read_issue;    // start a memory read at the request index
    logic read_capture;  // take the memory read data as result
    logic shift_start;   // set up the entry move for insert or delete
    logic shift_step;    // advance the entry move by one entry
    logic commit;        // write the new value on an insert and update the count
    logic emit;          // load the result register
  } cmd_t;

  typedef struct packed {
    kind_t kind;         // decode of the captured request
    logic  shift_idle;   // no entry move in flight
    logic  out_free;     // result register can take a new result
  } dp_status_t;

endpackage

[design/isl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/isl_ctrl.sv]
// Controller FSM of the indexed sequence list.
// Depends on isl_pkg for states, kinds and the command/status structs.
module isl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  isl_pkg::dp_status_t st,
  output isl_pkg::cmd_t       cmd
);

  isl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      isl_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = isl_pkg::S_DECODE;
        end
      end
      isl_pkg::S_DECODE: begin
        cmd.decide = 1'b1;
        case (st.kind)
          isl_pkg::K_READ: begin
            cmd.read_issue = 1'b1;
            state_nxt      = isl_pkg::S_READ;
          end
          isl_pkg::K_INSERT, isl_pkg::K_DELETE: begin
            cmd.shift_start = 1'b1;
            state_nxt       = isl_pkg::S_SHIFT;
          end
          default: begin
            state_nxt = isl_pkg::S_DONE;
          end
        endcase
      end
      isl_pkg::S_READ: begin
        cmd.read_capture = 1'b1;
        state_nxt        = isl_pkg::S_DONE;
      end
      isl_pkg::S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (st.shift_idle) begin
          state_nxt = isl_pkg::S_COMMIT;
        end
      end
      isl_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = isl_pkg::S_DONE;
      end
      isl_pkg::S_DONE: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = isl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = isl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[design/isl_datapath.sv]
// Datapath of the indexed sequence list: request registers, count, entry
// move sequencer, entry RAM and result register. Depends on isl_pkg, isl_ram.
`include "assert_macros.svh"

module isl_datapath #(
  parameter int DEPTH = isl_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  isl_pkg::cmd_t                       cmd,
  output isl_pkg::dp_status_t                 st,
  input  logic [2:0]                          in_op,
  input  logic signed [isl_pkg::INDEX_W-1:0]  in_index,
  input  logic signed [isl_pkg::DATA_W-1:0]   in_value,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [isl_pkg::DATA_W-1:0]   out_read_value,
  output logic [1:0]                          out_status,
  output logic [isl_pkg::COUNT_OUT_W-1:0]     out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Captured request.
  logic [2:0]                   op_r;
  logic [isl_pkg::INDEX_W-1:0]  idx_r;
  logic [isl_pkg::DATA_W-1:0]   value_r;

  // Decision latched before the count moves.
  logic                         is_ins_r;
  logic [CW-1:0]                pos_r;
  isl_pkg::status_t             code_r;
  logic [isl_pkg::DATA_W-1:0]   res_rd_r;

  logic [CW-1:0]                count_r;

  // Entry move sequencer.
  logic [CW-1:0]                ptr_r;
  logic                         run_r;
  logic                         pend_r;
  logic [AW-1:0]                pend_addr_r;

  // Result register.
  logic                         out_valid_r;
  logic [isl_pkg::DATA_W-1:0]   out_rd_r;
  isl_pkg::status_t             out_code_r;
  logic [CW-1:0]                out_cnt_r;

  // Decode.
  logic                         neg;
  logic [31:0]                  idx_mag;
  logic [31:0]                  cnt32;
  logic                         in_range;
  logic                         full;
  isl_pkg::kind_t               kind_c;
  isl_pkg::status_t             code_c;
  logic [isl_pkg::DATA_W-1:0]   rd_c;
  logic [CW-1:0]                pos_c;

  // RAM ports.
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [isl_pkg::DATA_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [isl_pkg::DATA_W-1:0]   ram_rdata;

  logic                         last_move;
  logic [CW-1:0]                move_dst;
  logic [31:0]                  out_cnt_ext;

  always_comb begin
    neg      = idx_r[isl_pkg::INDEX_W-1];
    idx_mag  = 32'(idx_r[isl_pkg::INDEX_W-2:0]);
    cnt32    = 32'(count_r);
    in_range = !neg && (idx_mag < cnt32);
    full     = (cnt32 == 32'(DEPTH));
    kind_c   = isl_pkg::K_REJECT;
    code_c   = isl_pkg::ST_RANGE;
    rd_c     = '0;
    pos_c    = idx_mag[CW-1:0];
    case (op_r)
      isl_pkg::OP_READ: begin
        if (in_range) begin
          kind_c = isl_pkg::K_READ;
          code_c = isl_pkg::ST_DONE;
        end else begin
          rd_c = '1;
        end
      end
      isl_pkg::OP_ADD_HEAD: begin
        pos_c = '0;
        if (full) begin
          code_c = isl_pkg::ST_FULL;
        end else begin
          kind_c = isl_pkg::K_INSERT;
          code_c = isl_pkg::ST_DONE;
        end
      end
      isl_pkg::OP_ADD_TAIL: begin
        pos_c = count_r;
        if (full) begin
          code_c = isl_pkg::ST_FULL;
        end else begin
          kind_c = isl_pkg::K_INSERT;
          code_c = isl_pkg::ST_DONE;
        end
      end
      isl_pkg::OP_ADD_AT: begin
        // A negative index inserts at the head; the range check wins over full.
        if (neg) begin
          pos_c = '0;
        end
        if (!neg && (idx_mag > cnt32)) begin
          code_c = isl_pkg::ST_RANGE;
        end else if (full) begin
          code_c = isl_pkg::ST_FULL;
        end else begin
          kind_c = isl_pkg::K_INSERT;
          code_c = isl_pkg::ST_DONE;
        end
      end
      isl_pkg::OP_DELETE: begin
        if (in_range) begin
          kind_c = isl_pkg::K_DELETE;
          code_c = isl_pkg::ST_DONE;
        end
      end
      default: begin
        code_c = isl_pkg::ST_RANGE;
      end
    endcase
  end

  // An insert reads from the top down and writes one place higher; a delete
  // reads from the gap upward and writes one place lower.
  always_comb begin
    if (is_ins_r) begin
      last_move = (ptr_r == pos_r);
      move_dst  = ptr_r + CW'(1);
    end else begin
      last_move = (ptr_r == count_r - CW'(1));
      move_dst  = ptr_r - CW'(1);
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr_r[AW-1:0];
    if (cmd.read_issue) begin
      ram_re    = 1'b1;
      ram_raddr = pos_c[AW-1:0];
    end else if (cmd.shift_step && run_r) begin
      ram_re = 1'b1;
    end
    ram_we    = 1'b0;
    ram_waddr = pend_addr_r;
    ram_wdata = ram_rdata;
    if (cmd.commit && is_ins_r) begin
      ram_we    = 1'b1;
      ram_waddr = pos_r[AW-1:0];
      ram_wdata = value_r;
    end else if (cmd.shift_step && pend_r) begin
      ram_we = 1'b1;
    end
  end

  isl_ram #(
    .WIDTH (isl_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      idx_r   <= in_index;
      value_r <= in_value;
    end
    if (cmd.decide) begin
      is_ins_r <= (kind_c == isl_pkg::K_INSERT);
      pos_r    <= pos_c;
      code_r   <= code_c;
      res_rd_r <= rd_c;
    end
    if (cmd.read_capture) begin
      res_rd_r <= ram_rdata;
    end
    if (cmd.shift_start) begin
      if (kind_c == isl_pkg::K_INSERT) begin
        ptr_r <= count_r - CW'(1);
      end else begin
        ptr_r <= pos_c + CW'(1);
      end
    end else if (cmd.shift_step && run_r) begin
      ptr_r <= is_ins_r ? ptr_r - CW'(1) : ptr_r + CW'(1);
    end
    if (cmd.shift_step && run_r) begin
      pend_addr_r <= move_dst[AW-1:0];
    end
    if (cmd.emit) begin
      out_rd_r   <= res_rd_r;
      out_code_r <= code_r;
      out_cnt_r  <= count_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      run_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count_r <= is_ins_r ? count_r + CW'(1) : count_r - CW'(1);
      end
      if (cmd.shift_start) begin
        // Nothing to move when inserting at the tail or deleting the last entry.
        if (kind_c == isl_pkg::K_INSERT) begin
          run_r <= (count_r != pos_c);
        end else begin
          run_r <= (pos_c + CW'(1) != count_r);
        end
        pend_r <= 1'b0;
      end else if (cmd.shift_step) begin
        pend_r <= run_r;
        if (run_r && last_move) begin
          run_r <= 1'b0;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.kind       = kind_c;
  assign st.shift_idle = !run_r && !pend_r;
  assign st.out_free   = !out_valid_r || out_ready;

  assign out_cnt_ext     = 32'(out_cnt_r);
  assign out_valid       = out_valid_r;
  assign out_read_value  = out_rd_r;
  assign out_status      = out_code_r;
  assign out_entry_count = out_cnt_ext[isl_pkg::COUNT_OUT_W-1:0];

  `ISL_ASSERT_NEVER(a_count_bound, count_r > CW'(DEPTH), "entry count above depth")
  `ISL_ASSERT_NEVER(a_wr_clash, cmd.commit && pend_r, "commit overlaps a pending move write")
  `ISL_ASSERT(a_ins_count, (cmd.commit && is_ins_r) |=> (count_r == $past(count_r) + CW'(1)), "insert did not grow the count")

endmodule

[design/indexed_sequence_list.sv]
// Top level of the indexed sequence list: stream ports around the controller
// and datapath. Depends on isl_pkg, isl_ctrl, isl_datapath (and isl_ram below).
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in_     | slave     | in_tvalid/in_tready | op, index, value
//  out_    | master    | out_tvalid/out_tready | read_value, status, entry_count
//
// A read goes through decode and a RAM read to its result; a rejected request goes
// from decode straight to the result. An insert or delete first moves the affected
// entries in the entry RAM, one entry per cycle (up to DEPTH-1 entries), then commits.
// Synchronous active-low reset empties the store; entry contents are not cleared.
// A new beat is accepted the cycle after a result is loaded, even while it waits on
// out_tready; the next result waits in the controller until the result register frees.
module indexed_sequence_list #(
  parameter int DEPTH = isl_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // op [2:0], index [18:3], value [50:19], zeros above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_value [31:0], status [33:32], entry_count [40:34]
);

  isl_pkg::cmd_t       cmd;
  isl_pkg::dp_status_t st;

  logic signed [isl_pkg::DATA_W-1:0]  rd_value;
  logic [1:0]                         status;
  logic [isl_pkg::COUNT_OUT_W-1:0]    entry_count;

  isl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  isl_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_op           (in_tdata[2:0]),
    .in_index        (in_tdata[18:3]),
    .in_value        (in_tdata[50:19]),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_read_value  (rd_value),
    .out_status      (status),
    .out_entry_count (entry_count)
  );

  assign out_tdata = {7'b0, entry_count, status, rd_value};

endmodule

[test/testbench.sv]
// Self-checking testbench for indexed_sequence_list: drives list requests on the
// input stream, predicts each response and compares it on the output stream.
// Depends on isl_pkg and the indexed_sequence_list RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH        = isl_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASES       = 4;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = DEPTH + 40;
  localparam int MAX_PRINTS   = 100;

  // Random segment flavors: build the list up, tear it down, or mixed traffic.
  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} traffic_mode_t;

  typedef struct packed {
    logic [31:0]                     read_value;
    isl_pkg::status_t                status;
    logic [isl_pkg::COUNT_OUT_W-1:0] entry_count;
  } response_t;

  class list_scoreboard;
    logic [isl_pkg::DATA_W-1:0] predicted_entries[$];
    response_t                  expected_responses[$];
    int                         errors;

    function int entry_total();
      return predicted_entries.size();
    endfunction

    function int outstanding();
      return expected_responses.size();
    endfunction

    function isl_pkg::status_t insert_entry(int pos, logic [isl_pkg::DATA_W-1:0] val);
      if (predicted_entries.size() >= DEPTH) return isl_pkg::ST_FULL;
      predicted_entries.insert(pos, val);
      return isl_pkg::ST_DONE;
    endfunction

    // Apply one accepted request to the predicted list and queue its response.
    function void note_request(logic [2:0] op, logic signed [isl_pkg::INDEX_W-1:0] index,
                               logic [isl_pkg::DATA_W-1:0] val);
      response_t rsp;
      int        pos;
      bit        in_range;
      pos = int'(index);
      in_range = (pos >= 0) && (pos < predicted_entries.size());
      rsp.read_value = '0;
      rsp.status = isl_pkg::ST_DONE;
      case (op)
        isl_pkg::OP_READ: begin
          if (in_range) begin
            rsp.read_value = predicted_entries[pos];
          end else begin
            rsp.read_value = '1;
            rsp.status = isl_pkg::ST_RANGE;
          end
        end
        isl_pkg::OP_ADD_HEAD: rsp.status = insert_entry(0, val);
        isl_pkg::OP_ADD_TAIL: rsp.status = insert_entry(predicted_entries.size(), val);
        isl_pkg::OP_ADD_AT: begin
          // The position check wins over the full check.
          if (pos > predicted_entries.size()) rsp.status = isl_pkg::ST_RANGE;
          else rsp.status = insert_entry((pos < 0) ? 0 : pos, val);
        end
        isl_pkg::OP_DELETE: begin
          if (in_range) predicted_entries.delete(pos);
          else rsp.status = isl_pkg::ST_RANGE;
        end
        default: rsp.status = isl_pkg::ST_RANGE;
      endcase
      rsp.entry_count = isl_pkg::COUNT_OUT_W'(predicted_entries.size());
      expected_responses.push_back(rsp);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS) $display("%0t MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [47:0] beat);
      response_t                       want;
      logic [31:0]                     got_value;
      logic [1:0]                      got_status;
      logic [isl_pkg::COUNT_OUT_W-1:0] got_count;
      got_value = beat[31:0];
      got_status = beat[33:32];
      got_count = beat[40:34];
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", beat));
        return;
      end
      want = expected_responses.pop_front();
      if (got_value !== want.read_value)
        report_mismatch($sformatf("read_value %h, expected %h", got_value, want.read_value));
      if (got_status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got_status, want.status));
      if (got_count !== want.entry_count)
        report_mismatch($sformatf("entry_count %0d, expected %0d", got_count,
                                  want.entry_count));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  list_scoreboard sb;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             quiet_cycles;

  indexed_sequence_list #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Present one request, with optional idle cycles first, and hold it until taken.
  task automatic send_item(logic [2:0] op, logic [isl_pkg::INDEX_W-1:0] index,
                           logic [isl_pkg::DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, val, index, op};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, index, val);
  endtask

  function automatic logic [isl_pkg::INDEX_W-1:0] pick_index(int cnt);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return isl_pkg::INDEX_W'($urandom_range((cnt > 0) ? cnt - 1 : 0));
      5:             return isl_pkg::INDEX_W'(cnt);
      6:             return isl_pkg::INDEX_W'(cnt + $urandom_range(1, 3));
      7:             return isl_pkg::INDEX_W'(-int'($urandom_range(1, 3)));
      8:             return isl_pkg::INDEX_W'($urandom());
      default:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  function automatic logic [isl_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_op(traffic_mode_t mode);
    isl_pkg::op_t order[5] = '{isl_pkg::OP_READ, isl_pkg::OP_ADD_HEAD, isl_pkg::OP_ADD_TAIL,
                               isl_pkg::OP_ADD_AT, isl_pkg::OP_DELETE};
    int  bounds[3][5] = '{'{5, 30, 55, 85, 95}, '{20, 27, 34, 44, 95},
                          '{30, 45, 60, 75, 95}};
    int  roll;
    roll = $urandom_range(99);
    for (int k = 0; k < 5; k++)
      if (roll < bounds[mode][k]) return order[k];
    return 3'($urandom_range((1 << $bits(isl_pkg::op_t)) - 1, isl_pkg::OP_DELETE + 1));
  endfunction

  task automatic run_directed();
    send_item(isl_pkg::OP_READ, 16'd0, 32'd0);
    send_item(isl_pkg::OP_DELETE, 16'd0, 32'd0);
    send_item(isl_pkg::OP_ADD_AT, 16'd1, 32'h1111_1111);     // past the end of an empty list
    send_item(isl_pkg::OP_ADD_AT, 16'h8000, 32'h8000_0000);  // negative index goes to the head
    send_item(isl_pkg::OP_ADD_HEAD, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(isl_pkg::OP_ADD_TAIL, 16'h7FFF, 32'hFFFF_FFFF);
    send_item(isl_pkg::OP_ADD_AT, 16'd3, 32'h0);             // index equal to count appends
    send_item(isl_pkg::OP_ADD_AT, 16'd1, 32'h1234_5678);
    send_item(isl_pkg::OP_ADD_AT, 16'd6, 32'h5555_AAAA);
    send_item(isl_pkg::OP_READ, 16'd0, 32'hFFFF_FFFF);
    send_item(isl_pkg::OP_READ, 16'd4, 32'd0);
    send_item(isl_pkg::OP_READ, 16'd5, 32'd0);
    send_item(isl_pkg::OP_READ, 16'hFFFF, 32'd0);
    send_item(isl_pkg::OP_READ, 16'h7FFF, 32'd0);
    send_item(isl_pkg::OP_READ, 16'h8000, 32'd0);
    for (int k = isl_pkg::OP_DELETE + 1; k < (1 << $bits(isl_pkg::op_t)); k++)
      send_item(3'(k), 16'hFFFF, 32'hFFFF_FFFF);
    send_item(isl_pkg::OP_DELETE, 16'hFFFF, 32'd0);
    send_item(isl_pkg::OP_DELETE, 16'd5, 32'd0);
    send_item(isl_pkg::OP_DELETE, 16'h7FFF, 32'd0);
    send_item(isl_pkg::OP_DELETE, 16'd4, 32'd0);
    send_item(isl_pkg::OP_DELETE, 16'd0, 32'd0);
    send_item(isl_pkg::OP_DELETE, 16'd1, 32'd0);
    send_item(isl_pkg::OP_READ, 16'd0, 32'd0);
    send_item(isl_pkg::OP_READ, 16'd1, 32'd0);
  endtask

  // Accept results with random backpressure and check them.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Ends a hung run: too many cycles in a row without a beat on either side.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int            idle_pcts[PHASES];
    int            stall_pcts[PHASES];
    traffic_mode_t mode;
    int            segment_left;
    logic [2:0]    op;
    idle_pcts = '{0, 49, 0, 23};
    stall_pcts = '{0, 0, 49, 23};
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // The first segment builds the list up until it is full and keeps pushing.
    mode = MODE_GROW;
    segment_left = 110;
    for (int phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = idle_pcts[phase];
      recv_stall_pct = stall_pcts[phase];
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (segment_left == 0) begin
          mode = traffic_mode_t'($urandom_range(MODE_MIX, MODE_GROW));
          segment_left = $urandom_range(20, 90);
        end
        segment_left--;
        op = pick_op(mode);
        send_item(op, pick_index(sb.entry_total()), pick_value());
      end
    end
    in_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[indexed_sequence_list.f]
+incdir+design
design/isl_pkg.sv
design/isl_ram.sv
design/isl_ctrl.sv
design/isl_datapath.sv
design/indexed_sequence_list.sv
test/testbench.sv
